// ----- rtl/esc_pkg.sv -----
`default_nettype none

package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
    logic [17:0]        press_hpa;
    logic [6:0]         hum_pct;
    logic               press_div_zero;
  } result_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } coef_t;

  localparam logic [2:0] REG_TEMP     = 3'd0;
  localparam logic [2:0] REG_PRESS_LO = 3'd1;
  localparam logic [2:0] REG_PRESS_HI = 3'd2;
  localparam logic [2:0] REG_PRESS_P9 = 3'd3;
  localparam logic [2:0] REG_HUM_LO   = 3'd4;
  localparam logic [2:0] REG_HUM_HI   = 3'd5;

  localparam logic [63:0] PRESS_T_OFS  = 64'd128000;
  localparam logic [63:0] PRESS_BASE   = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HUM_T_OFS    = 32'd76800;
  localparam logic [31:0] HUM_RND_F1   = 32'd16384;
  localparam logic [31:0] HUM_G2_OFS   = 32'd32768;
  localparam logic [31:0] HUM_F2_OFS   = 32'd2097152;
  localparam logic [31:0] HUM_RND_F2   = 32'd8192;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;
  localparam logic [24:0] HPA_RND      = 25'd50;
  // ceil(2^32 / 100): exact quotient for every dividend below 2^30
  localparam logic [25:0] HPA_RECIP    = 26'd42949673;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    logic signed [31:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
    logic signed [63:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  function automatic logic [31:0] sx16_32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32_64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/esc_delay.sv -----
`default_nettype none

module esc_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[N-1];

endmodule

`default_nettype wire

// ----- rtl/esc_mul64.sv -----
`default_nettype none

// Low 64 bits of a 64 x 64 product, two stages: partial products, then sum.
module esc_mul64 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[31:0] * b[31:0];
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
      p  <= ll + {lh + hl, 32'b0};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/esc_div.sv -----
`default_nettype none

// Signed 64 / 31-bit-magnitude divide, truncating toward zero.
// Restoring radix-2, four quotient bits per stage.
module esc_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [31:0] den,
  output logic      [63:0] q
);

  localparam int unsigned STEPS  = 4;
  localparam int unsigned NSTAGE = 64 / STEPS;

  logic [30:0] rem_s [NSTAGE+1];
  logic [63:0] dvd_s [NSTAGE+1];
  logic [30:0] ad_s  [NSTAGE];
  logic        neg_s [NSTAGE+1];
  logic [63:0] nnum;
  logic [31:0] nden;

  assign nnum = 64'd0 - num;
  assign nden = 32'd0 - den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= '0;
      dvd_s[0] <= num[63] ? nnum : num;
      ad_s[0]  <= den[31] ? nden[30:0] : den[30:0];
      neg_s[0] <= num[63] ^ den[31];
    end
  end

  for (genvar j = 1; j <= NSTAGE; j++) begin : g_stage
    logic [30:0] r;
    logic [63:0] v;
    logic [31:0] t;
    logic [31:0] diff;

    always_comb begin
      r    = rem_s[j-1];
      v    = dvd_s[j-1];
      t    = '0;
      diff = '0;
      for (int k = 0; k < STEPS; k++) begin
        t    = {r, v[63]};
        v    = {v[62:0], 1'b0};
        diff = t - {1'b0, ad_s[j-1]};
        if (t >= {1'b0, ad_s[j-1]}) begin
          r    = diff[30:0];
          v[0] = 1'b1;
        end else begin
          r = t[30:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j] <= r;
        dvd_s[j] <= v;
        neg_s[j] <= neg_s[j-1];
      end
    end

    if (j < NSTAGE) begin : g_ad
      always_ff @(posedge clk) begin
        if (en) begin
          ad_s[j] <= ad_s[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= neg_s[NSTAGE] ? 64'd0 - dvd_s[NSTAGE] : dvd_s[NSTAGE];
    end
  end

  // final remainder is not needed
  logic unused_rem;
  assign unused_rem = ^rem_s[NSTAGE];

endmodule

`default_nettype wire

// ----- rtl/esc_temp.sv -----
`default_nettype none

// Temperature: fine temperature after 4 stages, centidegrees after 5.
module esc_temp
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [19:0] raw_temp,
  input  wire coef_t       coef,
  output logic      [31:0] tfine,
  output logic      [31:0] temp_centi
);

  logic [17:0] da;
  logic [16:0] d;
  logic [31:0] ma;
  logic [31:0] dd;
  logic [31:0] a;
  logic [31:0] mb;

  always_ff @(posedge clk) begin
    if (en) begin
      da         <= {1'b0, raw_temp[19:3]} - {1'b0, coef.t1, 1'b0};
      d          <= {1'b0, raw_temp[19:4]} - {1'b0, coef.t1};
      ma         <= {{14{da[17]}}, da} * sx16_32(coef.t2);
      dd         <= {{15{d[16]}}, d} * {{15{d[16]}}, d};
      a          <= asr32(ma, 11);
      mb         <= asr32(dd, 12) * sx16_32(coef.t3);
      tfine      <= a + asr32(mb, 14);
      temp_centi <= asr32(tfine * 32'd5 + 32'd128, 8);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/esc_hum.sv -----
`default_nettype none

// Humidity, 32-bit wrapping math.
module esc_hum
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] tfine,
  input  wire logic [15:0] raw_hum,
  input  wire coef_t       coef,
  output logic      [16:0] hum,
  output logic      [6:0]  pct
);

  logic [31:0] x;
  logic [15:0] ah1;
  logic [15:0] ah2;
  logic [31:0] m5;
  logic [31:0] m6;
  logic [31:0] m3;
  logic [31:0] f1;
  logic [31:0] f1d1;
  logic [31:0] f1d2;
  logic [31:0] f1d3;
  logic [31:0] g;
  logic [31:0] g2;
  logic [31:0] mgg;
  logic [31:0] m2;
  logic [31:0] f2;
  logic [31:0] xm;
  logic [31:0] xmd1;
  logic [31:0] xmd2;
  logic [31:0] sq;
  logic [31:0] m1;
  logic [31:0] x2;
  logic [31:0] xc;
  logic [16:0] hum_c;
  logic [17:0] pct_sum;

  assign x2 = xmd2 - asr32(m1, 4);

  // clamp to 0..100 percent
  always_comb begin
    if (x2[31]) begin
      xc = '0;
    end else if (x2 > HUM_MAX) begin
      xc = HUM_MAX;
    end else begin
      xc = x2;
    end
  end

  assign pct_sum = {1'b0, hum_c} + 18'd512;

  always_ff @(posedge clk) begin
    if (en) begin
      x     <= tfine - HUM_T_OFS;
      ah1   <= raw_hum;
      ah2   <= ah1;
      m5    <= sx16_32(coef.h5) * x;
      m6    <= x * sx8_32(coef.h6);
      m3    <= x * {24'b0, coef.h3};
      f1    <= asr32({2'b0, ah2, 14'b0} - {coef.h4[11:0], 20'b0} - m5 + HUM_RND_F1, 15);
      g     <= asr32(m6, 10);
      g2    <= asr32(m3, 11) + HUM_G2_OFS;
      mgg   <= g * g2;
      f1d1  <= f1;
      m2    <= (asr32(mgg, 10) + HUM_F2_OFS) * sx16_32(coef.h2);
      f1d2  <= f1d1;
      f2    <= asr32(m2 + HUM_RND_F2, 14);
      f1d3  <= f1d2;
      xm    <= f1d3 * f2;
      sq    <= asr32(xm, 15) * asr32(xm, 15);
      xmd1  <= xm;
      m1    <= asr32(sq, 7) * {24'b0, coef.h1};
      xmd2  <= xmd1;
      hum_c <= xc[28:12];
      hum   <= hum_c;
      pct   <= pct_sum[16:10];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/esc_press.sv -----
`default_nettype none

// Pressure, 64-bit wrapping math with a pipelined divide.
module esc_press
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] tfine,
  input  wire logic [19:0] raw_press,
  input  wire coef_t       coef,
  output logic      [31:0] press,
  output logic      [17:0] hpa,
  output logic             div_zero
);

  logic [63:0] v1;
  logic [63:0] sq;
  logic [63:0] v1p5;
  logic [63:0] v1p2;
  logic [63:0] v1p5_d;
  logic [63:0] v1p2_d;
  logic [63:0] sqp6;
  logic [63:0] sqp3;
  logic [19:0] ap_d;
  logic [63:0] n0;
  logic [63:0] vv;
  logic [63:0] num;
  logic [63:0] dfull;
  logic [31:0] den;
  logic        dz;
  logic        dz_d;
  logic [63:0] q;
  logic [63:0] pp;
  logic [63:0] qp8;
  logic [63:0] qp8_d;
  logic [63:0] q_d;
  logic [63:0] w1raw;
  logic [63:0] s;
  logic [63:0] pf;
  logic [31:0] press32;
  logic        dz32;
  logic [24:0] hx;
  logic [50:0] prod;
  logic [31:0] press33;
  logic        dz33;

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= sx32_64(tfine) - PRESS_T_OFS;
    end
  end

  esc_mul64 u_sq (.clk, .en, .a(v1), .b(v1), .p(sq));
  esc_mul64 u_p5 (.clk, .en, .a(v1), .b(sx16_64(coef.p5)), .p(v1p5));
  esc_mul64 u_p2 (.clk, .en, .a(v1), .b(sx16_64(coef.p2)), .p(v1p2));
  esc_mul64 u_p6 (.clk, .en, .a(sq), .b(sx16_64(coef.p6)), .p(sqp6));
  esc_mul64 u_p3 (.clk, .en, .a(sq), .b(sx16_64(coef.p3)), .p(sqp3));

  esc_delay #(.W(64), .N(2)) u_d_p5 (.clk, .en, .d(v1p5), .q(v1p5_d));
  esc_delay #(.W(64), .N(2)) u_d_p2 (.clk, .en, .d(v1p2), .q(v1p2_d));
  esc_delay #(.W(20), .N(5)) u_d_ap (.clk, .en, .d(raw_press), .q(ap_d));

  always_ff @(posedge clk) begin
    if (en) begin
      n0 <= ((PRESS_BASE - {44'b0, ap_d}) << 31)
            - (sqp6 + (v1p5_d << 17) + (sx16_64(coef.p4) << 35));
      vv <= PRESS_BIAS + asr64(sqp3, 8) + (v1p2_d << 12);
    end
  end

  esc_mul64 u_num (.clk, .en, .a(n0), .b(PRESS_SCALE), .p(num));
  esc_mul64 u_den (.clk, .en, .a(vv), .b({48'b0, coef.p1}), .p(dfull));

  // divisor fits 31 bits after the shift by 33
  assign den = {dfull[63], dfull[63:33]};

  always_ff @(posedge clk) begin
    if (en) begin
      dz <= (den == 32'd0);
    end
  end

  esc_delay #(.W(1), .N(22)) u_d_dz (.clk, .en, .d(dz), .q(dz_d));

  esc_div u_div (.clk, .en, .num(num), .den(den), .q(q));

  esc_mul64 u_pp (.clk, .en, .a(asr64(q, 13)), .b(asr64(q, 13)), .p(pp));
  esc_mul64 u_p8 (.clk, .en, .a(q), .b(sx16_64(coef.p8)), .p(qp8));
  esc_mul64 u_p9 (.clk, .en, .a(pp), .b(sx16_64(coef.p9)), .p(w1raw));

  esc_delay #(.W(64), .N(2)) u_d_qp8 (.clk, .en, .d(qp8), .q(qp8_d));
  esc_delay #(.W(64), .N(4)) u_d_q   (.clk, .en, .d(q), .q(q_d));

  assign pf = asr64(s, 8) + (sx16_64(coef.p7) << 4);
  assign hx = {1'b0, press32[31:8]} + HPA_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      s        <= q_d + asr64(w1raw, 25) + asr64(qp8_d, 19);
      press32  <= dz_d ? 32'd0 : pf[31:0];
      dz32     <= dz_d;
      prod     <= 51'(hx) * 51'(HPA_RECIP);
      press33  <= press32;
      dz33     <= dz32;
      hpa      <= prod[49:32];
      press    <= press33;
      div_zero <= dz33;
    end
  end

  logic unused_prod;
  assign unused_prod = ^{prod[50], prod[31:0]};

endmodule

`default_nettype wire

// ----- rtl/env_sensor_compensation.sv -----
`default_nettype none

// channel   dir  handshake                    word
// sample    in   sample_valid / sample_ready  sample_t: raw temp, press, hum
// result    out  result_valid / result_ready  result_t: compensated values
// cfg       in   cfg_we (no wait)             cfg_idx selects a coefficient word
//
// One word enters per cycle unless a stall at the result port holds the pipe;
// a result passes the input register and 4 temperature stages to fine
// temperature, which feeds a 34-stage pressure path of which the 64-bit divide
// takes 18; humidity and temperature are delayed to match. rst clears valid
// bits and coefficients to zero. A stall at the result port freezes all
// stages; the input register still takes a word while it is empty.
module env_sensor_compensation
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire sample_t     sample,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned LAT = 38;

  logic [47:0] reg_temp;
  logic [63:0] reg_plo;
  logic [63:0] reg_phi;
  logic [15:0] reg_p9;
  logic [31:0] reg_hlo;
  logic [39:0] reg_hhi;
  coef_t       coef;

  logic            v0;
  sample_t         samp_q;
  logic            load;
  logic            en;
  logic [LAT-1:0]  vld;

  logic [31:0] tfine;
  logic [31:0] temp_c;
  logic [31:0] temp_d;
  logic [19:0] ap4;
  logic [15:0] ah4;
  logic [16:0] hum;
  logic [6:0]  pct;
  logic [23:0] hum_d;
  logic [31:0] press;
  logic [17:0] hpa;
  logic        dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_temp <= '0;
      reg_plo  <= '0;
      reg_phi  <= '0;
      reg_p9   <= '0;
      reg_hlo  <= '0;
      reg_hhi  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TEMP:     reg_temp <= cfg_data[47:0];
        REG_PRESS_LO: reg_plo  <= cfg_data;
        REG_PRESS_HI: reg_phi  <= cfg_data;
        REG_PRESS_P9: reg_p9   <= cfg_data[15:0];
        REG_HUM_LO:   reg_hlo  <= cfg_data[31:0];
        REG_HUM_HI:   reg_hhi  <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = reg_temp[15:0];
    coef.t2 = reg_temp[31:16];
    coef.t3 = reg_temp[47:32];
    coef.p1 = reg_plo[15:0];
    coef.p2 = reg_plo[31:16];
    coef.p3 = reg_plo[47:32];
    coef.p4 = reg_plo[63:48];
    coef.p5 = reg_phi[15:0];
    coef.p6 = reg_phi[31:16];
    coef.p7 = reg_phi[47:32];
    coef.p8 = reg_phi[63:48];
    coef.p9 = reg_p9;
    coef.h1 = reg_hlo[7:0];
    coef.h2 = reg_hlo[23:8];
    coef.h3 = reg_hlo[31:24];
    coef.h4 = reg_hhi[15:0];
    coef.h5 = reg_hhi[31:16];
    coef.h6 = reg_hhi[39:32];
  end

  // advance the pipe unless the result word is stuck
  assign en           = !vld[LAT-1] || result_ready;
  assign load         = en || !v0;
  assign sample_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      vld <= '0;
    end else begin
      if (load) begin
        v0 <= sample_valid;
      end
      if (en) begin
        vld <= {vld[LAT-2:0], v0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      samp_q <= sample;
    end
  end

  esc_temp u_temp (
    .clk, .en, .raw_temp(samp_q.raw_temp), .coef,
    .tfine(tfine), .temp_centi(temp_c)
  );

  esc_delay #(.W(20), .N(4)) u_d_ap (.clk, .en, .d(samp_q.raw_press), .q(ap4));
  esc_delay #(.W(16), .N(4)) u_d_ah (.clk, .en, .d(samp_q.raw_hum), .q(ah4));

  esc_press u_press (
    .clk, .en, .tfine(tfine), .raw_press(ap4), .coef,
    .press(press), .hpa(hpa), .div_zero(dz)
  );

  esc_hum u_hum (
    .clk, .en, .tfine(tfine), .raw_hum(ah4), .coef,
    .hum(hum), .pct(pct)
  );

  esc_delay #(.W(32), .N(33)) u_d_temp (.clk, .en, .d(temp_c), .q(temp_d));
  esc_delay #(.W(24), .N(23)) u_d_hum  (.clk, .en, .d({hum, pct}), .q(hum_d));

  assign result_valid          = vld[LAT-1];
  assign result.temp_centi     = temp_d;
  assign result.press_q24_8    = press;
  assign result.hum_q22_10     = hum_d[23:7];
  assign result.press_hpa      = hpa;
  assign result.hum_pct        = hum_d[6:0];
  assign result.press_div_zero = dz;

endmodule

`default_nettype wire
